// ----- sv/ccol_pkg.sv -----
// shared types and constants for the circle collision tester
// used by ccol_sqrt, ccol_div and circle_shape_collision_test; no dependencies
package ccol_pkg;

    typedef enum logic [1:0] {
        REQ_POINT  = 2'd0,
        REQ_CIRCLE = 2'd1,
        REQ_RECT   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    // q2.14 unit and the distance below which the normal is forced upward
    localparam int NORM_ONE = 16384;
    localparam int NORM_EPS = 6;

    // squared distance, its root, divider numerator and quotient widths
    localparam int SQ_W   = 66;
    localparam int ROOT_W = 33;
    localparam int NUM_W  = 48;
    localparam int Q_W    = 15;

endpackage

// ----- sv/ccol_sqrt.sv -----
// pipelined integer square root, two root bits per stage, floor result
// depends on ccol_pkg; carries an opaque sideband word beside each value
module ccol_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ccol_pkg::SQ_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ccol_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int RW  = ccol_pkg::ROOT_W;
    localparam int SW  = ccol_pkg::SQ_W;
    localparam int SPS = 2;
    localparam int NST = (RW + SPS - 1) / SPS;

    logic              r_vld  [NST];
    logic [RW+1:0]     r_rem  [NST];
    logic [RW-1:0]     r_root [NST];
    logic [SW-1:0]     r_rad  [NST];
    logic [SIDE_W-1:0] r_side [NST];
    logic [NST:0]      rdy;

    assign rdy[NST] = i_ready;

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic              vin;
        logic [RW+1:0]     rem_in;
        logic [RW-1:0]     root_in;
        logic [SW-1:0]     rad_in;
        logic [SIDE_W-1:0] side_in;
        logic [RW+1:0]     n_rem;
        logic [RW-1:0]     n_root;
        logic [SW-1:0]     n_rad;

        if (k == 0) begin : g_first
            assign vin     = i_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
            assign side_in = i_side;
        end else begin : g_next
            assign vin     = r_vld[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
            assign side_in = r_side[k-1];
        end

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        always_comb begin
            logic [RW+2:0] acc;
            logic [RW+2:0] trial;
            acc    = '0;
            trial  = '0;
            n_rem  = rem_in;
            n_root = root_in;
            n_rad  = rad_in;
            for (int j = 0; j < SPS; j++) begin
                if (k * SPS + j < RW) begin
                    acc   = {n_rem[RW:0], n_rad[SW-1 -: 2]};
                    trial = {1'b0, n_root, 2'b01};
                    if (acc >= trial) begin
                        n_rem  = (RW+2)'(acc - trial);
                        n_root = {n_root[RW-2:0], 1'b1};
                    end else begin
                        n_rem  = acc[RW+1:0];
                        n_root = {n_root[RW-2:0], 1'b0};
                    end
                    n_rad = {n_rad[SW-3:0], 2'b00};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= vin;
            end
            if (rdy[k] && vin) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_rad[k]  <= n_rad;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_root  = r_root[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ----- sv/ccol_div.sv -----
// pipelined restoring divider for both normal components, two quotient bits per stage
// depends on ccol_pkg; quotient must fit in Q_W bits, sideband passes through
module ccol_div #(
    parameter int SIDE_W = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [ccol_pkg::NUM_W-1:0]  i_numx,
    input  logic [ccol_pkg::NUM_W-1:0]  i_numy,
    input  logic [ccol_pkg::ROOT_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [ccol_pkg::Q_W-1:0]    o_qx,
    output logic [ccol_pkg::Q_W-1:0]    o_qy,
    output logic [SIDE_W-1:0]           o_side
);
    localparam int NW  = ccol_pkg::NUM_W;
    localparam int QW  = ccol_pkg::Q_W;
    localparam int DW  = ccol_pkg::ROOT_W;
    localparam int SPS = 2;
    localparam int NST = (QW + SPS - 1) / SPS;

    logic              r_vld  [NST];
    logic [NW-1:0]     r_remx [NST];
    logic [NW-1:0]     r_remy [NST];
    logic [QW-1:0]     r_qx   [NST];
    logic [QW-1:0]     r_qy   [NST];
    logic [DW-1:0]     r_den  [NST];
    logic [SIDE_W-1:0] r_side [NST];
    logic [NST:0]      rdy;

    assign rdy[NST] = i_ready;

    for (genvar k = 0; k < NST; k++) begin : g_st
        logic              vin;
        logic [NW-1:0]     remx_in;
        logic [NW-1:0]     remy_in;
        logic [QW-1:0]     qx_in;
        logic [QW-1:0]     qy_in;
        logic [DW-1:0]     den_in;
        logic [SIDE_W-1:0] side_in;
        logic [NW-1:0]     n_remx;
        logic [NW-1:0]     n_remy;
        logic [QW-1:0]     n_qx;
        logic [QW-1:0]     n_qy;

        if (k == 0) begin : g_first
            assign vin     = i_valid;
            assign remx_in = i_numx;
            assign remy_in = i_numy;
            assign qx_in   = '0;
            assign qy_in   = '0;
            assign den_in  = i_den;
            assign side_in = i_side;
        end else begin : g_next
            assign vin     = r_vld[k-1];
            assign remx_in = r_remx[k-1];
            assign remy_in = r_remy[k-1];
            assign qx_in   = r_qx[k-1];
            assign qy_in   = r_qy[k-1];
            assign den_in  = r_den[k-1];
            assign side_in = r_side[k-1];
        end

        assign rdy[k] = !r_vld[k] || rdy[k+1];

        always_comb begin
            logic [NW-1:0] dk;
            int            sh;
            dk     = '0;
            sh     = 0;
            n_remx = remx_in;
            n_remy = remy_in;
            n_qx   = qx_in;
            n_qy   = qy_in;
            for (int j = 0; j < SPS; j++) begin
                if (k * SPS + j < QW) begin
                    sh = QW - 1 - (k * SPS + j);
                    dk = NW'(den_in) << sh;
                    if (n_remx >= dk) begin
                        n_remx = n_remx - dk;
                        n_qx   = {n_qx[QW-2:0], 1'b1};
                    end else begin
                        n_qx   = {n_qx[QW-2:0], 1'b0};
                    end
                    if (n_remy >= dk) begin
                        n_remy = n_remy - dk;
                        n_qy   = {n_qy[QW-2:0], 1'b1};
                    end else begin
                        n_qy   = {n_qy[QW-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= vin;
            end
            if (rdy[k] && vin) begin
                r_remx[k] <= n_remx;
                r_remy[k] <= n_remy;
                r_qx[k]   <= n_qx;
                r_qy[k]   <= n_qy;
                r_den[k]  <= den_in;
                r_side[k] <= side_in;
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_vld[NST-1];
    assign o_qx    = r_qx[NST-1];
    assign o_qy    = r_qy[NST-1];
    assign o_side  = r_side[NST-1];

endmodule

// ----- sv/circle_shape_collision_test.sv -----
// circle versus point, circle or rectangle collision tester, top level
// depends on ccol_pkg, ccol_sqrt and ccol_div
//
//   channel   dir  tuser            tdata
//   s_axis    in   req_type         one shape pair to test
//   m_axis    out  -                hit flag, contact, normal, depth
//
// one word accepted per cycle while m_axis back pressure does not stall the pipeline
// the pipeline holds the square root unit (17 stages, two root bits each)
// and the normal divider (8 stages), plus 10 stages of setup and finish
// every stage holds its word under back pressure; empty stages still fill
// synchronous active low reset clears the stage valid bits only
module circle_shape_collision_test #(
    parameter int COORD_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // center_x, center_y, circle_radius, scale_x, scale_y,
    // opnd_a, opnd_b, opnd_c, opnd_d, opnd_e, zero fill
    input  logic [319:0] s_axis_tdata,
    // req_type
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // collided, contact_x, contact_y, normal_x, normal_y, depth, zero fill
    output logic [135:0] m_axis_tdata
);
    localparam int CWE = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int SH  = 32 - CWE;
    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (CWE - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef struct packed {
        ccol_pkg::t_req     typ;
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } t_base;

    typedef struct packed {
        t_base              b;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic [45:0]        r;
        logic signed [63:0] rop;
    } t_f1;

    typedef struct packed {
        t_base              b;
        logic signed [32:0] vx;
        logic signed [32:0] vy;
        logic [45:0]        r;
        logic signed [49:0] rsel;
        logic [65:0]        sqx;
        logic [65:0]        sqy;
    } t_f2;

    typedef struct packed {
        t_base              b;
        logic               sxn;
        logic               syn;
        logic [32:0]        mx;
        logic [32:0]        my;
        logic [45:0]        r;
        logic signed [49:0] rsel;
        logic [65:0]        s;
        logic [47:0]        hh;
        logic [47:0]        hl;
        logic [47:0]        ll;
    } t_f3;

    typedef struct packed {
        t_base              b;
        logic               hit;
        logic               sxn;
        logic               syn;
        logic [32:0]        mx;
        logic [32:0]        my;
        logic [45:0]        r;
        logic signed [49:0] rsel;
    } t_side;

    typedef struct packed {
        t_base              b;
        logic               sxn;
        logic               syn;
        logic [32:0]        mx;
        logic [32:0]        my;
        logic [45:0]        r;
        logic signed [49:0] rsel;
        logic [65:0]        s;
        logic [95:0]        r2;
    } t_f4;

    typedef struct packed {
        t_side                       sd;
        logic [ccol_pkg::ROOT_W-1:0] d;
        logic                        small_d;
    } t_mid;

    typedef struct packed {
        t_base              b;
        logic               hit;
        logic [45:0]        r;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [50:0] dep;
    } t_b1;

    typedef struct packed {
        t_base              b;
        logic               hit;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [50:0] dep;
        logic signed [39:0] pxl;
        logic signed [39:0] pxh;
        logic signed [39:0] pyl;
        logic signed [39:0] pyh;
    } t_b2;

    typedef struct packed {
        t_base              b;
        logic               hit;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [50:0] dep;
        logic signed [48:0] tx;
        logic signed [48:0] ty;
    } t_b3;

    typedef struct packed {
        logic        collided;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [15:0] nx;
        logic [15:0] ny;
        logic [31:0] dep;
    } t_out;

    localparam int SIDE_W = $bits(t_side);
    localparam int MID_W  = $bits(t_mid);

    function automatic logic [31:0] f_sat(input logic signed [63:0] v);
        logic signed [63:0] c;
        c = (v > SAT_HI) ? SAT_HI : ((v < SAT_LO) ? SAT_LO : v);
        return c[31:0];
    endfunction

    // handshake chain: a stage loads when empty or when its successor moves
    logic rdy_f1, rdy_f2, rdy_f3, rdy_f4, rdy_f5, rdy_m1;
    logic rdy_b1, rdy_b2, rdy_b3, rdy_out;
    logic r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld, r_f5_vld, r_m1_vld;
    logic r_b1_vld, r_b2_vld, r_b3_vld, r_out_vld;

    t_f1   r_f1, n_f1;
    t_f2   r_f2, n_f2;
    t_f3   r_f3, n_f3;
    t_f4   r_f4, n_f4;
    t_side r_f5, n_f5;
    logic [65:0] r_f5_s;
    t_mid  r_m1, n_m1;
    logic [ccol_pkg::NUM_W-1:0] r_m1_numx, r_m1_numy, n_m1_numx, n_m1_numy;
    t_b1   r_b1, n_b1;
    t_b2   r_b2, n_b2;
    t_b3   r_b3, n_b3;
    t_out  r_out, n_out;

    logic                        sq_in_rdy, sq_out_vld;
    logic [ccol_pkg::ROOT_W-1:0] sq_root;
    logic [SIDE_W-1:0]           sq_side;
    logic                        dv_in_rdy, dv_out_vld;
    logic [ccol_pkg::Q_W-1:0]    dv_qx, dv_qy;
    logic [MID_W-1:0]            dv_side;

    assign rdy_out = !r_out_vld || m_axis_tready;
    assign rdy_b3  = !r_b3_vld || rdy_out;
    assign rdy_b2  = !r_b2_vld || rdy_b3;
    assign rdy_b1  = !r_b1_vld || rdy_b2;
    assign rdy_m1  = !r_m1_vld || dv_in_rdy;
    assign rdy_f5  = !r_f5_vld || sq_in_rdy;
    assign rdy_f4  = !r_f4_vld || rdy_f5;
    assign rdy_f3  = !r_f3_vld || rdy_f4;
    assign rdy_f2  = !r_f2_vld || rdy_f3;
    assign rdy_f1  = !r_f1_vld || rdy_f2;
    assign s_axis_tready = rdy_f1;

    // input unpack, coordinates sign-extended from the active width
    logic        [31:0] in_cx, in_cy, in_a, in_b, in_c, in_d;
    logic        [30:0] in_rad, in_scx, in_scy, in_e;
    logic signed [31:0] cx_s, cy_s, a_s, b_s, c_s, d_s;

    assign in_cx  = s_axis_tdata[31:0];
    assign in_cy  = s_axis_tdata[63:32];
    assign in_rad = s_axis_tdata[94:64];
    assign in_scx = s_axis_tdata[125:95];
    assign in_scy = s_axis_tdata[156:126];
    assign in_a   = s_axis_tdata[188:157];
    assign in_b   = s_axis_tdata[220:189];
    assign in_c   = s_axis_tdata[252:221];
    assign in_d   = s_axis_tdata[284:253];
    assign in_e   = s_axis_tdata[315:285];

    assign cx_s = $signed(in_cx << SH) >>> SH;
    assign cy_s = $signed(in_cy << SH) >>> SH;
    assign a_s  = $signed(in_a << SH) >>> SH;
    assign b_s  = $signed(in_b << SH) >>> SH;
    assign c_s  = $signed(in_c << SH) >>> SH;
    assign d_s  = $signed(in_d << SH) >>> SH;

    // stage f1: rectangle clamp, difference vector, both radius products
    always_comb begin
        logic signed [31:0] px1, py1, pxc, pyc;
        logic [30:0]        scm, em;
        logic [61:0]        rp;
        px1 = (cx_s < a_s) ? a_s : cx_s;
        py1 = (cy_s < b_s) ? b_s : cy_s;
        pxc = (px1 > c_s) ? c_s : px1;
        pyc = (py1 > d_s) ? d_s : py1;
        scm = (in_scx > in_scy) ? in_scx : in_scy;
        rp  = in_rad * scm;
        // the other circle's y scale is never negative, so the max is too
        em  = (d_s > $signed({1'b0, in_e})) ? d_s[30:0] : in_e;
        n_f1.b.typ = ccol_pkg::t_req'(s_axis_tuser);
        n_f1.b.cx  = cx_s;
        n_f1.b.cy  = cy_s;
        n_f1.b.px  = pxc;
        n_f1.b.py  = pyc;
        if (ccol_pkg::t_req'(s_axis_tuser) == ccol_pkg::REQ_RECT) begin
            n_f1.vx = {cx_s[31], cx_s} - {pxc[31], pxc};
            n_f1.vy = {cy_s[31], cy_s} - {pyc[31], pyc};
        end else begin
            n_f1.vx = {a_s[31], a_s} - {cx_s[31], cx_s};
            n_f1.vy = {b_s[31], b_s} - {cy_s[31], cy_s};
        end
        n_f1.r   = rp[61:16];
        n_f1.rop = c_s * $signed({1'b0, em});
    end

    // stage f2: other radius truncated toward zero, radius sum, squares
    always_comb begin
        logic signed [63:0] rob;
        logic signed [47:0] ro;
        logic signed [49:0] sum;
        logic signed [65:0] sqx, sqy;
        rob = r_f1.rop + (r_f1.rop[63] ? 64'sh0000_0000_0000_FFFF : 64'sh0);
        ro  = rob[63:16];
        sum = $signed({4'b0, r_f1.r}) + $signed({{2{ro[47]}}, ro});
        sqx = $signed(r_f1.vx) * $signed(r_f1.vx);
        sqy = $signed(r_f1.vy) * $signed(r_f1.vy);
        n_f2.b    = r_f1.b;
        n_f2.vx   = r_f1.vx;
        n_f2.vy   = r_f1.vy;
        n_f2.r    = r_f1.r;
        n_f2.rsel = (r_f1.b.typ == ccol_pkg::REQ_CIRCLE) ? sum : $signed({4'b0, r_f1.r});
        n_f2.sqx  = sqx;
        n_f2.sqy  = sqy;
    end

    // stage f3: squared distance, partial products of the squared radius
    always_comb begin
        logic [47:0] rm;
        rm = r_f2.rsel[47:0];
        n_f3.b    = r_f2.b;
        n_f3.sxn  = r_f2.vx[32];
        n_f3.syn  = r_f2.vy[32];
        n_f3.mx   = r_f2.vx[32] ? (~r_f2.vx + 33'd1) : r_f2.vx;
        n_f3.my   = r_f2.vy[32] ? (~r_f2.vy + 33'd1) : r_f2.vy;
        n_f3.r    = r_f2.r;
        n_f3.rsel = r_f2.rsel;
        n_f3.s    = r_f2.sqx + r_f2.sqy;
        n_f3.hh   = rm[47:24] * rm[47:24];
        n_f3.hl   = rm[47:24] * rm[23:0];
        n_f3.ll   = rm[23:0] * rm[23:0];
    end

    // stage f4: squared radius assembled
    always_comb begin
        n_f4.b    = r_f3.b;
        n_f4.sxn  = r_f3.sxn;
        n_f4.syn  = r_f3.syn;
        n_f4.mx   = r_f3.mx;
        n_f4.my   = r_f3.my;
        n_f4.r    = r_f3.r;
        n_f4.rsel = r_f3.rsel;
        n_f4.s    = r_f3.s;
        n_f4.r2   = {r_f3.hh, 48'b0} + {23'b0, r_f3.hl, 25'b0} + {48'b0, r_f3.ll};
    end

    // stage f5: exact hit test, a negative radius never hits
    always_comb begin
        n_f5.b    = r_f4.b;
        n_f5.hit  = !r_f4.rsel[49] && ({30'b0, r_f4.s} <= r_f4.r2);
        n_f5.sxn  = r_f4.sxn;
        n_f5.syn  = r_f4.syn;
        n_f5.mx   = r_f4.mx;
        n_f5.my   = r_f4.my;
        n_f5.r    = r_f4.r;
        n_f5.rsel = r_f4.rsel;
    end

    ccol_sqrt #(
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f5_vld),
        .o_ready (sq_in_rdy),
        .i_rad   (r_f5_s),
        .i_side  (r_f5),
        .o_valid (sq_out_vld),
        .i_ready (rdy_m1),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // stage m1: rounded numerators for the normal, near-zero distance flag
    always_comb begin
        t_side sd;
        sd = t_side'(sq_side);
        n_m1.sd      = sd;
        n_m1.d       = sq_root;
        n_m1.small_d = (sq_root <= ccol_pkg::ROOT_W'(ccol_pkg::NORM_EPS));
        n_m1_numx    = {1'b0, sd.mx, 14'b0} + ccol_pkg::NUM_W'(sq_root >> 1);
        n_m1_numy    = {1'b0, sd.my, 14'b0} + ccol_pkg::NUM_W'(sq_root >> 1);
    end

    ccol_div #(
        .SIDE_W (MID_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m1_vld),
        .o_ready (dv_in_rdy),
        .i_numx  (r_m1_numx),
        .i_numy  (r_m1_numy),
        .i_den   (r_m1.d),
        .i_side  (r_m1),
        .o_valid (dv_out_vld),
        .i_ready (rdy_b1),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy),
        .o_side  (dv_side)
    );

    // stage b1: signed normal with the near-zero repair, depth
    always_comb begin
        t_mid                     md;
        logic [ccol_pkg::Q_W-1:0] qxc, qyc;
        md  = t_mid'(dv_side);
        qxc = (dv_qx > ccol_pkg::Q_W'(ccol_pkg::NORM_ONE)) ?
              ccol_pkg::Q_W'(ccol_pkg::NORM_ONE) : dv_qx;
        qyc = (dv_qy > ccol_pkg::Q_W'(ccol_pkg::NORM_ONE)) ?
              ccol_pkg::Q_W'(ccol_pkg::NORM_ONE) : dv_qy;
        n_b1.b   = md.sd.b;
        n_b1.hit = md.sd.hit;
        n_b1.r   = md.sd.r;
        if (md.small_d) begin
            n_b1.nx = 16'sd0;
            n_b1.ny = 16'(ccol_pkg::NORM_ONE);
        end else begin
            n_b1.nx = md.sd.sxn ? -$signed({1'b0, qxc}) : $signed({1'b0, qxc});
            n_b1.ny = md.sd.syn ? -$signed({1'b0, qyc}) : $signed({1'b0, qyc});
        end
        n_b1.dep = $signed({md.sd.rsel[49], md.sd.rsel}) - $signed({18'b0, md.d});
    end

    // stage b2: normal times own radius, radius split in two halves
    always_comb begin
        n_b2.b   = r_b1.b;
        n_b2.hit = r_b1.hit;
        n_b2.nx  = r_b1.nx;
        n_b2.ny  = r_b1.ny;
        n_b2.dep = r_b1.dep;
        n_b2.pxl = r_b1.nx * $signed({1'b0, r_b1.r[22:0]});
        n_b2.pxh = r_b1.nx * $signed({1'b0, r_b1.r[45:23]});
        n_b2.pyl = r_b1.ny * $signed({1'b0, r_b1.r[22:0]});
        n_b2.pyh = r_b1.ny * $signed({1'b0, r_b1.r[45:23]});
    end

    // stage b3: product joined, shifted back to q16.16 toward zero
    always_comb begin
        logic signed [62:0] prx, pry, bx, by;
        prx = $signed({r_b2.pxh, 23'b0}) + $signed({{23{r_b2.pxl[39]}}, r_b2.pxl});
        pry = $signed({r_b2.pyh, 23'b0}) + $signed({{23{r_b2.pyl[39]}}, r_b2.pyl});
        bx  = prx + (prx[62] ? 63'sd16383 : 63'sd0);
        by  = pry + (pry[62] ? 63'sd16383 : 63'sd0);
        n_b3.b   = r_b2.b;
        n_b3.hit = r_b2.hit;
        n_b3.nx  = r_b2.nx;
        n_b3.ny  = r_b2.ny;
        n_b3.dep = r_b2.dep;
        n_b3.tx  = bx[62:14];
        n_b3.ty  = by[62:14];
    end

    // output stage: contact point, saturation, zero result on a point or rectangle miss
    always_comb begin
        logic signed [49:0] ccx, ccy;
        logic [31:0]        dsat;
        ccx  = $signed({{18{r_b3.b.cx[31]}}, r_b3.b.cx}) + $signed({r_b3.tx[48], r_b3.tx});
        ccy  = $signed({{18{r_b3.b.cy[31]}}, r_b3.b.cy}) + $signed({r_b3.ty[48], r_b3.ty});
        dsat = f_sat({{13{r_b3.dep[50]}}, r_b3.dep});
        n_out = '0;
        case (r_b3.b.typ)
            ccol_pkg::REQ_POINT: begin
                if (r_b3.hit) begin
                    n_out.collided = 1'b1;
                    n_out.cx       = r_b3.b.cx;
                    n_out.cy       = r_b3.b.cy;
                    n_out.nx       = r_b3.nx;
                    n_out.ny       = r_b3.ny;
                    n_out.dep      = dsat;
                end
            end
            ccol_pkg::REQ_CIRCLE: begin
                // circle pairs report every field, hit or not
                n_out.collided = r_b3.hit;
                n_out.cx       = f_sat({{14{ccx[49]}}, ccx});
                n_out.cy       = f_sat({{14{ccy[49]}}, ccy});
                n_out.nx       = r_b3.nx;
                n_out.ny       = r_b3.ny;
                n_out.dep      = dsat;
            end
            ccol_pkg::REQ_RECT: begin
                if (r_b3.hit) begin
                    n_out.collided = 1'b1;
                    n_out.cx       = r_b3.b.px;
                    n_out.cy       = r_b3.b.py;
                    n_out.nx       = r_b3.nx;
                    n_out.ny       = r_b3.ny;
                    n_out.dep      = dsat;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_f3_vld  <= 1'b0;
            r_f4_vld  <= 1'b0;
            r_f5_vld  <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_b1_vld  <= 1'b0;
            r_b2_vld  <= 1'b0;
            r_b3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (rdy_f1)  r_f1_vld  <= s_axis_tvalid;
            if (rdy_f2)  r_f2_vld  <= r_f1_vld;
            if (rdy_f3)  r_f3_vld  <= r_f2_vld;
            if (rdy_f4)  r_f4_vld  <= r_f3_vld;
            if (rdy_f5)  r_f5_vld  <= r_f4_vld;
            if (rdy_m1)  r_m1_vld  <= sq_out_vld;
            if (rdy_b1)  r_b1_vld  <= dv_out_vld;
            if (rdy_b2)  r_b2_vld  <= r_b1_vld;
            if (rdy_b3)  r_b3_vld  <= r_b2_vld;
            if (rdy_out) r_out_vld <= r_b3_vld;
        end
    end

    // payload registers, loaded only with a valid word
    always_ff @(posedge i_clk) begin
        if (rdy_f1 && s_axis_tvalid) r_f1 <= n_f1;
        if (rdy_f2 && r_f1_vld)      r_f2 <= n_f2;
        if (rdy_f3 && r_f2_vld)      r_f3 <= n_f3;
        if (rdy_f4 && r_f3_vld)      r_f4 <= n_f4;
        if (rdy_f5 && r_f4_vld) begin
            r_f5   <= n_f5;
            r_f5_s <= r_f4.s;
        end
        if (rdy_m1 && sq_out_vld) begin
            r_m1      <= n_m1;
            r_m1_numx <= n_m1_numx;
            r_m1_numy <= n_m1_numy;
        end
        if (rdy_b1 && dv_out_vld)    r_b1  <= n_b1;
        if (rdy_b2 && r_b1_vld)      r_b2  <= n_b2;
        if (rdy_b3 && r_b2_vld)      r_b3  <= n_b3;
        if (rdy_out && r_b3_vld)     r_out <= n_out;
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'b0, r_out.dep, r_out.ny, r_out.nx,
                            r_out.cy, r_out.cx, r_out.collided};

`ifndef NO_ASSERTIONS
    // normal components stay within one unit
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ($signed(r_out.nx) >= -16'sd16384 && $signed(r_out.nx) <= 16'sd16384
                    && $signed(r_out.ny) >= -16'sd16384 && $signed(r_out.ny) <= 16'sd16384))
        else $error("normal out of range");

    // a hit never reports a negative penetration depth
    a_hit_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.collided) |-> !r_out.dep[31])
        else $error("negative depth on hit");

    // a stalled first stage keeps its word
    a_f1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_f1_vld && !rdy_f2) |=> (r_f1_vld && $stable(r_f1)))
        else $error("first stage lost a word");
`endif

endmodule
